// File: hdl/lspb_pkg.sv
`timescale 1ns / 1ps

package lspb_pkg;

  // Default number of angle bins per revolution.
  localparam int NUM_BINS_DEF = 360;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 9;
  localparam int DIST_W  = 16;
  localparam int ANGLE_W = 15;

  // Header framing.
  localparam logic [7:0] SYNC_FIRST      = 8'hA5;
  localparam logic [7:0] SYNC_SECOND     = 8'h5A;
  localparam logic [2:0] HEADER_SYNC_LEN = 3'd2;
  localparam logic [2:0] HEADER_END      = 3'd7;

  // Index of the fifth (last) byte of a measurement packet.
  localparam logic [2:0] PKT_LAST = 3'd4;

  // Full circle in Q6 degrees.
  localparam logic [14:0] FULL_CIRCLE_Q6 = 15'd23040;

  // Right shift of the reciprocal multiply used for angle binning.
  localparam int RECIP_SHIFT = 30;

  // Width of the per-bank epoch tag kept beside each stored distance.
  localparam int EPOCH_W = 3;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  // Parser phases.
  localparam logic [1:0] PH_SYNC1 = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_DESC  = 2'd2;
  localparam logic [1:0] PH_SCAN  = 2'd3;

  // Input modes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 1'd1;
  localparam logic [15:0] RANGE_MIN_RST = 16'd600;
  localparam logic [15:0] RANGE_MAX_RST = 16'd48000;

  typedef logic [1:0] phase_t;

endpackage

// File: hdl/lidar_scan_parse_and_bin.sv
`timescale 1ns / 1ps

// Scan packet parser and angle binner for a serial scanning range sensor.
// Input channel (in_valid/in_ready): each transaction is either one received
// sensor byte (in_mode = 0) or a read of one bin of the ready scan bank
// (in_mode = 1, in_slot, in_release_req). Every input transaction gives
// exactly one result transaction on the output channel (out_valid/out_ready).
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the distance limits
// and take effect at once; write them only while the block is idle.
// Each accepted transaction passes from the input register to the output
// register, where its result is presented. Throughput: one transaction per
// cycle while no clearing pass runs and the receiver keeps taking results.
// Reset clears the parser and bank control and then runs a clearing pass over
// all 2 * 2**clog2(NUM_BINS) entries of the distance memory (1024 for 360 bins),
// during which in_ready stays low. Each bank carries an epoch tag; on every
// eighth reuse of a bank its epoch runs out and a clearing pass over the
// bank's NUM_BINS entries follows the bank swap, holding off processing meanwhile.
// When the receiver stalls, the output register holds its result and one more
// transaction can still be accepted into the input register before in_ready
// falls.
module lidar_scan_parse_and_bin #(
  parameter int NUM_BINS = lspb_pkg::NUM_BINS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_mode,
  input  logic [lspb_pkg::BYTE_W-1:0]            in_rx_byte,
  input  logic [lspb_pkg::SLOT_W-1:0]            in_slot,
  input  logic                                   in_release_req,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_scan_ready,
  output logic [lspb_pkg::DIST_W-1:0]            out_read_distance,
  output logic                                   out_point_stored,
  output logic [lspb_pkg::SLOT_W-1:0]            out_point_bin,
  output logic [lspb_pkg::DIST_W-1:0]            out_point_distance,
  output logic                                   out_banks_swapped,
  // Configuration port
  input  logic                                   cfg_we,
  input  logic [lspb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lspb_pkg::DIST_W-1:0]            cfg_wdata
);

  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int MEM_DEPTH = 2 ** (BIN_W + 1);
  localparam int MEM_W     = lspb_pkg::EPOCH_W + lspb_pkg::DIST_W;
  localparam longint unsigned CIRCLE = longint'(lspb_pkg::FULL_CIRCLE_Q6);
  localparam longint unsigned BIN_MULT =
    ((longint'(NUM_BINS) << lspb_pkg::RECIP_SHIFT) + CIRCLE - 1) / CIRCLE;
  localparam int MULT_W = $clog2(BIN_MULT + 1);
  localparam int PROD_W = lspb_pkg::ANGLE_W + MULT_W;
  localparam logic [MULT_W-1:0] BIN_MULT_C = MULT_W'(BIN_MULT);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

  localparam int EW = lspb_pkg::EPOCH_W;
  localparam int DW = lspb_pkg::DIST_W;

  // Input register
  logic                          s1_v_r;
  logic                          s1_mode_r;
  logic [lspb_pkg::BYTE_W-1:0]   s1_byte_r;
  logic [lspb_pkg::SLOT_W-1:0]   s1_slot_r;
  logic                          s1_release_r;
  logic                          advance;
  logic                          in_fire;

  // Parser and bank state
  lspb_pkg::phase_t              phase_r, phase_nxt;
  logic [2:0]                    hdr_cnt_r, hdr_cnt_nxt;
  logic [2:0]                    pkt_idx_r, pkt_idx_nxt;
  logic [lspb_pkg::BYTE_W-1:0]   pkt_b_r [4];
  logic                          pkt_we;
  logic                          fill_bank_r, fill_bank_nxt;
  logic                          has_data_r, has_data_nxt;
  logic                          ready_r, ready_nxt;
  logic [1:0][EW-1:0]            epoch_r, epoch_nxt;
  logic [DW-1:0]                 range_min_r, range_max_r;

  // Clearing pass
  logic                          scrub_r, scrub_nxt;
  logic                          scrub_all_r, scrub_all_nxt;
  logic [BIN_W:0]                scrub_cnt_r, scrub_cnt_nxt;
  logic                          scrub_done;
  logic                          scrub_start;
  logic                          pend_v_r, pend_v_nxt;
  logic [BIN_W-1:0]              pend_bin_r, pend_bin_nxt;
  logic [DW-1:0]                 pend_dist_r, pend_dist_nxt;

  // Distance memory
  logic [MEM_W-1:0]              store_mem [MEM_DEPTH];
  logic [MEM_W-1:0]              mem_q_r;
  logic                          mem_we;
  logic [BIN_W:0]                mem_waddr;
  logic [MEM_W-1:0]              mem_wdata;
  logic [BIN_W:0]                mem_raddr;

  // Packet decode
  logic                          pkt_ok;
  logic                          pkt_start;
  logic [lspb_pkg::ANGLE_W-1:0]  angle;
  logic [DW-1:0]                 pkt_dist;
  logic [PROD_W-1:0]             bin_prod;
  logic [BIN_W-1:0]              bin;
  logic                          point_ok;
  logic                          read_hit;
  logic                          swap;
  logic                          store;

  // Result
  logic                          res_ready;
  logic [DW-1:0]                 res_read;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_scan_ready_r;
  logic [DW-1:0]                 out_read_distance_r;
  logic                          out_point_stored_r;
  logic [lspb_pkg::SLOT_W-1:0]   out_point_bin_r;
  logic [DW-1:0]                 out_point_distance_r;
  logic                          out_banks_swapped_r;

  // Handshake: the stage advances when the output register is free and no clearing pass runs.
  assign advance  = s1_v_r && !scrub_r && (!out_valid_r || out_ready);
  assign in_ready = !scrub_r && (!s1_v_r || advance);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_mode;
      s1_byte_r    <= in_rx_byte;
      s1_slot_r    <= in_slot;
      s1_release_r <= in_release_req;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= lspb_pkg::RANGE_MIN_RST;
      range_max_r <= lspb_pkg::RANGE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lspb_pkg::REG_RANGE_MIN: range_min_r <= cfg_wdata;
        lspb_pkg::REG_RANGE_MAX: range_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Packet fields. The fifth byte is the one in the input register.
  assign pkt_ok    = (pkt_b_r[0][0] != pkt_b_r[0][1]) && pkt_b_r[1][0];
  assign pkt_start = pkt_b_r[0][0];
  assign angle     = {pkt_b_r[2], pkt_b_r[1][7:1]};
  assign pkt_dist  = {s1_byte_r, pkt_b_r[3]};

  // Bin by reciprocal multiply; exact for every angle below a full circle,
  // which is also exactly the condition for the bin to lie inside the bank.
  assign bin_prod = PROD_W'(angle) * PROD_W'(BIN_MULT_C);
  assign bin      = bin_prod[lspb_pkg::RECIP_SHIFT +: BIN_W];
  assign point_ok = (angle < lspb_pkg::FULL_CIRCLE_Q6) && (pkt_dist != '0) &&
                    (pkt_dist >= range_min_r) && (pkt_dist <= range_max_r);

  // A stored entry counts only if its tag matches its bank's current epoch.
  assign read_hit = ready_r && (32'(s1_slot_r) < 32'(NUM_BINS)) &&
                    (mem_q_r[MEM_W-1 -: EW] == epoch_r[~fill_bank_r]);

  // Item processing and next state.
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    pkt_idx_nxt   = pkt_idx_r;
    pkt_we        = 1'b0;
    fill_bank_nxt = fill_bank_r;
    has_data_nxt  = has_data_r;
    ready_nxt     = ready_r;
    epoch_nxt     = epoch_r;
    swap          = 1'b0;
    store         = 1'b0;
    scrub_start   = 1'b0;
    res_ready     = 1'b0;
    res_read      = '0;
    if (advance) begin
      if (s1_mode_r == lspb_pkg::MODE_READ) begin
        res_ready = ready_r;
        res_read  = read_hit ? mem_q_r[DW-1:0] : '0;
        if (s1_release_r) begin
          ready_nxt = 1'b0;
        end
      end else begin
        case (phase_r)
          lspb_pkg::PH_SYNC1: begin
            if (s1_byte_r == lspb_pkg::SYNC_FIRST) begin
              phase_nxt = lspb_pkg::PH_SYNC2;
            end
          end
          lspb_pkg::PH_SYNC2: begin
            if (s1_byte_r == lspb_pkg::SYNC_SECOND) begin
              hdr_cnt_nxt = lspb_pkg::HEADER_SYNC_LEN;
              phase_nxt   = lspb_pkg::PH_DESC;
            end else begin
              phase_nxt = lspb_pkg::PH_SYNC1;
            end
          end
          lspb_pkg::PH_DESC: begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            if (hdr_cnt_nxt >= lspb_pkg::HEADER_END) begin
              phase_nxt   = lspb_pkg::PH_SCAN;
              pkt_idx_nxt = '0;
            end
          end
          default: begin
            if (pkt_idx_r < lspb_pkg::PKT_LAST) begin
              pkt_we      = 1'b1;
              pkt_idx_nxt = pkt_idx_r + 3'd1;
            end else begin
              pkt_idx_nxt = '0;
              if (pkt_ok) begin
                // Start of a new revolution: swap banks and retire the old epoch.
                if (pkt_start && has_data_r) begin
                  swap          = 1'b1;
                  fill_bank_nxt = ~fill_bank_r;
                  ready_nxt     = 1'b1;
                  has_data_nxt  = 1'b0;
                  if (epoch_r[~fill_bank_r] == lspb_pkg::EPOCH_LAST) begin
                    epoch_nxt[~fill_bank_r] = '0;
                    scrub_start             = 1'b1;
                  end else begin
                    epoch_nxt[~fill_bank_r] = epoch_r[~fill_bank_r] + EW'(1);
                  end
                end
                if (point_ok) begin
                  store        = 1'b1;
                  has_data_nxt = 1'b1;
                end
              end
            end
          end
        endcase
        res_ready = ready_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lspb_pkg::PH_SYNC1;
      hdr_cnt_r   <= '0;
      pkt_idx_r   <= '0;
      fill_bank_r <= 1'b0;
      has_data_r  <= 1'b0;
      ready_r     <= 1'b0;
      epoch_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      pkt_idx_r   <= pkt_idx_nxt;
      fill_bank_r <= fill_bank_nxt;
      has_data_r  <= has_data_nxt;
      ready_r     <= ready_nxt;
      epoch_r     <= epoch_nxt;
    end
  end

  // Packet byte buffer.
  always_ff @(posedge clk) begin
    if (pkt_we) begin
      pkt_b_r[pkt_idx_r[1:0]] <= s1_byte_r;
    end
  end

  // Clearing pass control. A point stored by the swapping packet is held
  // and written by the pass itself.
  assign scrub_done = scrub_all_r ? (&scrub_cnt_r) : (scrub_cnt_r[BIN_W-1:0] == BIN_LAST);

  always_comb begin
    scrub_nxt     = scrub_r;
    scrub_all_nxt = scrub_all_r;
    scrub_cnt_nxt = scrub_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_bin_nxt  = pend_bin_r;
    pend_dist_nxt = pend_dist_r;
    if (scrub_start) begin
      scrub_nxt     = 1'b1;
      scrub_all_nxt = 1'b0;
      scrub_cnt_nxt = '0;
      pend_v_nxt    = store;
      pend_bin_nxt  = bin;
      pend_dist_nxt = pkt_dist;
    end else if (scrub_r) begin
      if (scrub_done) begin
        scrub_nxt  = 1'b0;
        pend_v_nxt = 1'b0;
      end else begin
        scrub_cnt_nxt = scrub_cnt_r + (BIN_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scrub_r     <= 1'b1;
      scrub_all_r <= 1'b1;
      scrub_cnt_r <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      scrub_r     <= scrub_nxt;
      scrub_all_r <= scrub_all_nxt;
      scrub_cnt_r <= scrub_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_bin_r  <= pend_bin_nxt;
    pend_dist_r <= pend_dist_nxt;
  end

  // Memory write port: clearing pass or a stored point.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (scrub_r) begin
      mem_we    = 1'b1;
      mem_waddr = scrub_all_r ? scrub_cnt_r : {fill_bank_r, scrub_cnt_r[BIN_W-1:0]};
      if (pend_v_r && !scrub_all_r && (scrub_cnt_r[BIN_W-1:0] == pend_bin_r)) begin
        mem_wdata = {EW'(0), pend_dist_r};
      end
    end else if (store && !scrub_start) begin
      mem_we    = 1'b1;
      mem_waddr = {fill_bank_nxt, bin};
      mem_wdata = {epoch_nxt[fill_bank_nxt], pkt_dist};
    end
  end

  // Read port follows the bank that is ready once the current item is done.
  assign mem_raddr = {~fill_bank_nxt, BIN_W'(in_slot)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_q_r <= store_mem[mem_raddr];
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_scan_ready_r     <= res_ready;
      out_read_distance_r  <= res_read;
      out_point_stored_r   <= store;
      out_point_bin_r      <= store ? lspb_pkg::SLOT_W'(bin) : '0;
      out_point_distance_r <= store ? pkt_dist : '0;
      out_banks_swapped_r  <= swap;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_scan_ready     = out_scan_ready_r;
  assign out_read_distance  = out_read_distance_r;
  assign out_point_stored   = out_point_stored_r;
  assign out_point_bin      = out_point_bin_r;
  assign out_point_distance = out_point_distance_r;
  assign out_banks_swapped  = out_banks_swapped_r;

  // No transaction is taken while the memory is being cleared.
  a_no_accept_in_scrub: assert property (@(posedge clk) disable iff (!rst_n)
    scrub_r |-> !in_ready)
    else $error("input accepted during clearing pass");

  // A swap always leaves a complete scan ready.
  a_swap_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_banks_swapped_r) |-> out_scan_ready_r)
    else $error("bank swap without ready flag");

  // Reads and stores never share a result.
  a_read_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_read_distance_r != '0)) |->
      (!out_point_stored_r && !out_banks_swapped_r))
    else $error("read result carries point fields");

  // A held point only exists during its clearing pass.
  a_pend_in_scrub: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (scrub_r && !scrub_all_r))
    else $error("pending point outside clearing pass");

  // A stored point is never written into the ready bank.
  a_store_fill_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !scrub_r) |=> (fill_bank_r == $past(mem_waddr[BIN_W])))
    else $error("point written outside the filling bank");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// One input transaction: a sensor byte or a read of one bin.
typedef struct packed {
  logic                        mode;
  logic [lspb_pkg::BYTE_W-1:0] rx_byte;
  logic [lspb_pkg::SLOT_W-1:0] slot;
  logic                        release_req;
} scan_item_t;

// One result transaction, fields in port order.
typedef struct packed {
  logic                        ready_out;
  logic [lspb_pkg::DIST_W-1:0] read_distance;
  logic                        point_stored;
  logic [lspb_pkg::SLOT_W-1:0] point_bin;
  logic [lspb_pkg::DIST_W-1:0] point_distance;
  logic                        banks_swapped;
} scan_result_t;

// Tracks the parser, the two distance banks and the limits, and keeps the
// results still owed by the block in arrival order.
class bin_scan_tracker;
  logic [lspb_pkg::DIST_W-1:0] range_min;
  logic [lspb_pkg::DIST_W-1:0] range_max;
  lspb_pkg::phase_t            phase;
  logic [2:0]                  header_count;
  logic [lspb_pkg::BYTE_W-1:0] pkt [4];
  logic [2:0]                  pkt_index;
  bit                          fill_bank;
  bit                          fill_has_data;
  bit                          ready_flag;
  logic [lspb_pkg::DIST_W-1:0] bank [2][lspb_pkg::NUM_BINS_DEF];
  scan_result_t                due_results [$];
  int                          mismatches;

  function new();
    range_min     = lspb_pkg::RANGE_MIN_RST;
    range_max     = lspb_pkg::RANGE_MAX_RST;
    phase         = lspb_pkg::PH_SYNC1;
    header_count  = '0;
    pkt_index     = '0;
    fill_bank     = 1'b0;
    fill_has_data = 1'b0;
    ready_flag    = 1'b0;
    mismatches    = 0;
    foreach (pkt[i]) pkt[i] = '0;
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < lspb_pkg::NUM_BINS_DEF; i++) bank[b][i] = '0;
  endfunction

  function void write_limit(logic [lspb_pkg::CFG_IDX_W-1:0] idx,
                            logic [lspb_pkg::DIST_W-1:0] val);
    if (idx == lspb_pkg::REG_RANGE_MIN) begin
      range_min = val;
    end else begin
      range_max = val;
    end
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  // Handles a complete measurement packet whose fifth byte is last_byte.
  function void take_packet(logic [lspb_pkg::BYTE_W-1:0] last_byte, inout scan_result_t r);
    logic [lspb_pkg::ANGLE_W-1:0] angle;
    logic [lspb_pkg::DIST_W-1:0]  pkt_dist;
    int unsigned                  bin;
    // Start bit must differ from its complement, and the check bit be set.
    if (pkt[0][0] == pkt[0][1] || !pkt[1][0]) return;
    // A new revolution with data in the filling bank swaps the banks.
    if (pkt[0][0] && fill_has_data) begin
      fill_bank     = ~fill_bank;
      ready_flag    = 1'b1;
      fill_has_data = 1'b0;
      for (int i = 0; i < lspb_pkg::NUM_BINS_DEF; i++) bank[fill_bank][i] = '0;
      r.banks_swapped = 1'b1;
    end
    angle    = {pkt[2], pkt[1][7:1]};
    pkt_dist = {last_byte, pkt[3]};
    if (pkt_dist == '0) return;
    bin = (32'(angle) * lspb_pkg::NUM_BINS_DEF) / 32'(lspb_pkg::FULL_CIRCLE_Q6);
    if (bin < lspb_pkg::NUM_BINS_DEF && pkt_dist >= range_min && pkt_dist <= range_max) begin
      bank[fill_bank][bin] = pkt_dist;
      fill_has_data        = 1'b1;
      r.point_stored       = 1'b1;
      r.point_bin          = bin[lspb_pkg::SLOT_W-1:0];
      r.point_distance     = pkt_dist;
    end
  endfunction

  // Works out the result of an accepted input transaction.
  function void note_accepted(scan_item_t it);
    scan_result_t r;
    r = '0;
    if (it.mode == lspb_pkg::MODE_READ) begin
      r.ready_out = ready_flag;
      if (ready_flag && it.slot < lspb_pkg::NUM_BINS_DEF)
        r.read_distance = bank[~fill_bank][it.slot];
      if (it.release_req) ready_flag = 1'b0;
    end else begin
      case (phase)
        lspb_pkg::PH_SYNC1: begin
          if (it.rx_byte == lspb_pkg::SYNC_FIRST) phase = lspb_pkg::PH_SYNC2;
        end
        lspb_pkg::PH_SYNC2: begin
          if (it.rx_byte == lspb_pkg::SYNC_SECOND) begin
            header_count = lspb_pkg::HEADER_SYNC_LEN;
            phase        = lspb_pkg::PH_DESC;
          end else begin
            phase = lspb_pkg::PH_SYNC1;
          end
        end
        lspb_pkg::PH_DESC: begin
          header_count = header_count + 3'd1;
          if (header_count >= lspb_pkg::HEADER_END) begin
            phase     = lspb_pkg::PH_SCAN;
            pkt_index = '0;
          end
        end
        default: begin
          if (pkt_index < lspb_pkg::PKT_LAST) begin
            pkt[pkt_index] = it.rx_byte;
            pkt_index      = pkt_index + 3'd1;
          end else begin
            take_packet(it.rx_byte, r);
            pkt_index = '0;
          end
        end
      endcase
      r.ready_out = ready_flag;
    end
    due_results.push_back(r);
  endfunction

  function string show(scan_result_t r);
    return $sformatf("ready=%0d rd=%0d stored=%0d bin=%0d dist=%0d swap=%0d",
                     r.ready_out, r.read_distance, r.point_stored, r.point_bin,
                     r.point_distance, r.banks_swapped);
  endfunction

  // Compares a result transaction with the oldest one owed.
  function void check_result(scan_result_t got);
    scan_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", show(got));
    end else begin
      want = due_results.pop_front();
      if (got.ready_out !== want.ready_out || got.read_distance !== want.read_distance ||
          got.point_stored !== want.point_stored || got.point_bin !== want.point_bin ||
          got.point_distance !== want.point_distance ||
          got.banks_swapped !== want.banks_swapped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %s, got %s", show(want), show(got));
      end
    end
  endfunction
endclass

module tb_top;

  localparam int LIMIT       = 200000;
  localparam int IDLE_PCT    = 8;
  localparam int BIN_SPAN_Q6 = lspb_pkg::FULL_CIRCLE_Q6 / lspb_pkg::NUM_BINS_DEF;
  localparam int PKT_LEN     = 5;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_mode;
  logic [lspb_pkg::BYTE_W-1:0]    in_rx_byte;
  logic [lspb_pkg::SLOT_W-1:0]    in_slot;
  logic                           in_release_req;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_scan_ready;
  logic [lspb_pkg::DIST_W-1:0]    out_read_distance;
  logic                           out_point_stored;
  logic [lspb_pkg::SLOT_W-1:0]    out_point_bin;
  logic [lspb_pkg::DIST_W-1:0]    out_point_distance;
  logic                           out_banks_swapped;
  logic                           cfg_we;
  logic [lspb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lspb_pkg::DIST_W-1:0]    cfg_wdata;

  bin_scan_tracker             tracker;
  bit                          quiet = 1'b0;
  int                          items_sent = 0;
  int                          frame_pos = 0;
  int unsigned                 cycle_count = 0;
  logic [lspb_pkg::DIST_W-1:0] lim_min = lspb_pkg::RANGE_MIN_RST;
  logic [lspb_pkg::DIST_W-1:0] lim_max = lspb_pkg::RANGE_MAX_RST;

  lidar_scan_parse_and_bin DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_rx_byte, .in_slot, .in_release_req,
    .out_valid, .out_ready, .out_scan_ready, .out_read_distance, .out_point_stored,
    .out_point_bin, .out_point_distance, .out_banks_swapped,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls now and then, except in quiet stretches.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every accepted result transaction is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result({out_scan_ready, out_read_distance, out_point_stored,
                            out_point_bin, out_point_distance, out_banks_swapped});
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Offers one transaction, after a random gap, and holds it until accepted.
  task automatic send_item(scan_item_t it);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_mode, in_rx_byte, in_slot, in_release_req} <= it;
    do @(posedge clk); while (!in_ready);
    tracker.note_accepted(it);
    items_sent++;
  endtask

  // The slot and release fields are random on byte transactions; the block ignores them.
  task automatic send_byte(logic [lspb_pkg::BYTE_W-1:0] b);
    send_item({lspb_pkg::MODE_BYTE, b, lspb_pkg::SLOT_W'($urandom), 1'($urandom)});
    frame_pos = (frame_pos + 1) % PKT_LEN;
  endtask

  task automatic send_read(logic [lspb_pkg::SLOT_W-1:0] slot, logic rel);
    send_item({lspb_pkg::MODE_READ, lspb_pkg::BYTE_W'($urandom), slot, rel});
  endtask

  task automatic send_packet(logic start, logic start_inv, logic check,
                             logic [lspb_pkg::ANGLE_W-1:0] angle,
                             logic [lspb_pkg::DIST_W-1:0] pkt_dist);
    logic [lspb_pkg::BYTE_W-1:0] b0;
    b0    = lspb_pkg::BYTE_W'($urandom);
    b0[0] = start;
    b0[1] = start_inv;
    send_byte(b0);
    send_byte({angle[6:0], check});
    send_byte(angle[14:7]);
    send_byte(pkt_dist[7:0]);
    send_byte(pkt_dist[15:8]);
  endtask

  // Lowers valid and waits until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic set_limits(logic [lspb_pkg::DIST_W-1:0] lo, logic [lspb_pkg::DIST_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= lspb_pkg::REG_RANGE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= lspb_pkg::REG_RANGE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_limit(lspb_pkg::REG_RANGE_MIN, lo);
    tracker.write_limit(lspb_pkg::REG_RANGE_MAX, hi);
    lim_min = lo;
    lim_max = hi;
  endtask

  // Reads favour the low bins, where most random points land.
  function automatic logic [lspb_pkg::SLOT_W-1:0] pick_slot();
    int p;
    p = $urandom_range(9);
    if (p < 5) return lspb_pkg::SLOT_W'($urandom_range(15));
    if (p < 8) return lspb_pkg::SLOT_W'($urandom_range(lspb_pkg::NUM_BINS_DEF - 1));
    return lspb_pkg::SLOT_W'($urandom);
  endfunction

  function automatic logic [lspb_pkg::ANGLE_W-1:0] pick_angle();
    int p;
    p = $urandom_range(9);
    if (p < 6)
      return lspb_pkg::ANGLE_W'($urandom_range(15) * BIN_SPAN_Q6 +
                                $urandom_range(BIN_SPAN_Q6 - 1));
    if (p < 8) return lspb_pkg::ANGLE_W'($urandom_range(lspb_pkg::FULL_CIRCLE_Q6 - 1));
    if (p == 9)
      return lspb_pkg::ANGLE_W'($urandom_range(32767, lspb_pkg::FULL_CIRCLE_Q6));
    case ($urandom_range(3))
      0:       return '0;
      1:       return lspb_pkg::ANGLE_W'(lspb_pkg::FULL_CIRCLE_Q6 - 1);
      2:       return lspb_pkg::FULL_CIRCLE_Q6;
      default: return '1;
    endcase
  endfunction

  // Distances cluster on the limits and just outside them.
  function automatic logic [lspb_pkg::DIST_W-1:0] pick_distance();
    case ($urandom_range(9))
      0:    return '0;
      1:    return '1;
      2:    return lim_min;
      3:    return lim_max;
      4:    return lim_min - 1'b1;
      5:    return lim_max + 1'b1;
      6, 7: begin
        if (lim_min <= lim_max) return lspb_pkg::DIST_W'($urandom_range(lim_max, lim_min));
        return lspb_pkg::DIST_W'($urandom);
      end
      default: return lspb_pkg::DIST_W'($urandom);
    endcase
  endfunction

  // Mostly framed packets with random content, some reads, stray bytes and
  // malformed packets. Framing is restored before each well-formed packet.
  task automatic random_phase(int n);
    int   stop_at;
    int   pick;
    logic start;
    logic start_inv;
    logic check;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_read(pick_slot(), $urandom_range(7) == 0);
      end else if (pick < 17) begin
        repeat ($urandom_range(PKT_LEN, 1)) send_byte(lspb_pkg::BYTE_W'($urandom));
      end else begin
        while (frame_pos != 0) send_byte(lspb_pkg::BYTE_W'($urandom));
        start     = ($urandom_range(11) == 0);
        start_inv = ~start;
        check     = 1'b1;
        case ($urandom_range(9))
          0:       start_inv = start;
          1:       check = 1'b0;
          2: begin
            start     = 1'b1;
            start_inv = 1'b1;
          end
          default: ;
        endcase
        send_packet(start, start_inv, check, pick_angle(), pick_distance());
      end
    end
  endtask

  initial begin
    tracker        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = lspb_pkg::MODE_BYTE;
    in_rx_byte     = '0;
    in_slot        = '0;
    in_release_req = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = lspb_pkg::REG_RANGE_MIN;
    cfg_wdata      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a read before any scan, a header hunt with wrong second
    // bytes, the descriptor, then two packets for both ends of the circle and
    // limits, which land out of frame, and reads in and out of range.
    send_read('0, 1'b1);
    send_byte(8'h00);
    send_byte(lspb_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_byte(lspb_pkg::SYNC_FIRST);
    send_byte(lspb_pkg::SYNC_FIRST);
    send_byte(lspb_pkg::SYNC_FIRST);
    send_byte(lspb_pkg::SYNC_SECOND);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(lspb_pkg::SYNC_FIRST);
    send_byte(lspb_pkg::SYNC_SECOND);
    repeat (5) send_byte(8'h81);
    frame_pos = 0;
    send_packet(1'b0, 1'b1, 1'b1, '0, lspb_pkg::RANGE_MIN_RST);
    send_packet(1'b1, 1'b0, 1'b1, lspb_pkg::ANGLE_W'(lspb_pkg::FULL_CIRCLE_Q6 - 1),
                lspb_pkg::RANGE_MAX_RST);
    send_read('0, 1'b0);
    send_read('1, 1'b1);
    drain();

    // Random phases, each under its own limits, with the block idle between.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_limits('0, '1);
        1:       set_limits(lspb_pkg::RANGE_MIN_RST, lspb_pkg::RANGE_MAX_RST);
        2:       set_limits('1, '1);
        3:       set_limits(16'd1000, 16'd3000);
        4:       set_limits('0, '0);
        default: set_limits(16'd1, 16'hFFFE);
      endcase
      quiet = (ph == 1);
      random_phase(250);
      drain();
    end
    quiet = 1'b0;

    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
